@@ rtl/fractional_period_sample_scheduler_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the sample scheduler
// Shorthand for clocked implication checks with a synchronous reset guard.
// ----------------------------------------------------------------------------
`ifndef FRACTIONAL_PERIOD_SAMPLE_SCHEDULER_ASSERT_SVH
`define FRACTIONAL_PERIOD_SAMPLE_SCHEDULER_ASSERT_SVH

// Same-cycle implication: when ante holds, cons holds at the same edge.
`define FPSS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scheduler check failed: same-cycle implication");

// Next-cycle implication: when ante holds, cons holds at the following edge.
`define FPSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scheduler check failed: next-cycle implication");

`endif

@@ rtl/fpss_pkg.sv @@
// ----------------------------------------------------------------------------
// fpss_pkg
// Types and constants shared by the sample scheduler modules.
// ----------------------------------------------------------------------------
package fpss_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned CfgW  = 20;
  localparam int unsigned AccW  = 20;

  // Register indexes (word address bits [3:2])
  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t RegBasePeriod = 2'd0;
  localparam reg_idx_t RegPeriodRem  = 2'd1;
  localparam reg_idx_t RegRateHz     = 2'd2;

  localparam logic [CfgW-1:0] BasePeriodReset = 20'd1250;
  localparam logic [CfgW-1:0] PeriodRemReset  = 20'd0;
  localparam logic [CfgW-1:0] RateHzReset     = 20'd800;

  typedef struct packed {
    logic [CfgW-1:0] base_period_us;
    logic [CfgW-1:0] period_remainder;
    logic [CfgW-1:0] rate_hz;
  } cfg_t;

  typedef struct packed {
    logic [TimeW-1:0] next_deadline;
    logic [AccW-1:0]  remainder_acc;
    logic [TimeW-1:0] previous_fire_time;
    logic             first_fire_pending;
    logic             deadline_loaded;
    logic [TimeW-1:0] missed_count;
  } sched_state_t;

  localparam sched_state_t StateReset = '{
    next_deadline:      '0,
    remainder_acc:      '0,
    previous_fire_time: '0,
    first_fire_pending: 1'b1,
    deadline_loaded:    1'b0,
    missed_count:       '0
  };

  typedef struct packed {
    logic             fired;
    logic [TimeW-1:0] late_by_us;
    logic [TimeW-1:0] fire_interval_us;
    logic             reanchored;
    logic [TimeW-1:0] missed_total;
  } result_t;

endpackage

@@ rtl/fpss_step.sv @@
// ----------------------------------------------------------------------------
// fpss_step
// One scheduler decision: fire test, miss handling, deadline advance.
// ----------------------------------------------------------------------------
module fpss_step (
  input  logic [fpss_pkg::TimeW-1:0] now_us,
  input  fpss_pkg::cfg_t             cfg,
  input  fpss_pkg::sched_state_t     state,
  output fpss_pkg::sched_state_t     state_next,
  output fpss_pkg::result_t          result
);

  logic [fpss_pkg::TimeW-1:0] deadline;
  logic [fpss_pkg::TimeW-1:0] late;
  logic                       fire;
  logic [fpss_pkg::CfgW:0]    late_limit;
  logic                       miss;
  logic [fpss_pkg::TimeW-1:0] anchor;
  logic [fpss_pkg::AccW-1:0]  acc_base;
  logic [fpss_pkg::AccW:0]    sum;
  logic                       carry;
  logic [fpss_pkg::AccW:0]    sum_adj;
  logic [fpss_pkg::TimeW-1:0] advanced;

  always_comb begin
    // The first item loads the deadline with its own time.
    deadline   = state.deadline_loaded ? state.next_deadline : now_us;
    late       = now_us - deadline;
    fire       = ~late[fpss_pkg::TimeW-1];
    late_limit = {1'b0, cfg.base_period_us} + {{fpss_pkg::CfgW{1'b0}}, 1'b1};
    miss       = fire &&
                 (late >= {{(fpss_pkg::TimeW-fpss_pkg::CfgW-1){1'b0}}, late_limit});

    // Re-anchor to now and drop the remainder on a missed deadline.
    anchor   = miss ? now_us : deadline;
    acc_base = miss ? '0 : state.remainder_acc;
    sum      = {1'b0, acc_base} + {1'b0, cfg.period_remainder};
    carry    = (sum >= {1'b0, cfg.rate_hz});
    sum_adj  = carry ? (sum - {1'b0, cfg.rate_hz}) : sum;
    advanced = anchor
             + {{(fpss_pkg::TimeW-fpss_pkg::CfgW){1'b0}}, cfg.base_period_us}
             + {{(fpss_pkg::TimeW-1){1'b0}}, carry};

    state_next                 = state;
    state_next.deadline_loaded = 1'b1;
    state_next.next_deadline   = deadline;
    if (fire) begin
      state_next.next_deadline      = advanced;
      state_next.remainder_acc      = sum_adj[fpss_pkg::AccW-1:0];
      state_next.previous_fire_time = now_us;
      state_next.first_fire_pending = 1'b0;
      state_next.missed_count       = state.missed_count
                                    + {{(fpss_pkg::TimeW-1){1'b0}}, miss};
    end

    result.fired            = fire;
    result.late_by_us       = fire ? late : '0;
    result.fire_interval_us = (fire && !state.first_fire_pending)
                            ? (now_us - state.previous_fire_time) : '0;
    result.reanchored       = miss;
    result.missed_total     = state_next.missed_count;
  end

endmodule

@@ rtl/fractional_period_sample_scheduler.sv @@
// ----------------------------------------------------------------------------
// fractional_period_sample_scheduler
// Decides per microsecond timestamp whether a sample is due, with a
// fractional period built from a whole part and a remainder accumulator.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake                      payload
//   now       in         now_valid / now_stall          now_us
//   result    out        result_valid / result_stall    fired, late_by_us,
//                                                       fire_interval_us,
//                                                       reanchored, missed_total
//   config    in         APB (psel, penable, pready)    paddr, pwdata, prdata
//
// One item per cycle sustained while the result is not stalled; each item passes the input
// register, then the result register, with the step logic between them: one subtract,
// one compare and one three-input add on the deadline.
// Synchronous active-high rst clears both pipeline valids, the scheduler
// state and loads the register defaults. A stalled result holds in the result
// register; the input register still advances into it when it is empty.
//
module fractional_period_sample_scheduler (
  input  logic        clk,
  input  logic        rst,

  // timestamp channel
  input  logic        now_valid,
  output logic        now_stall,
  input  logic [31:0] now_us,

  // result channel
  output logic        result_valid,
  input  logic        result_stall,
  output logic        fired,
  output logic [31:0] late_by_us,
  output logic [31:0] fire_interval_us,
  output logic        reanchored,
  output logic [31:0] missed_total,

  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  fpss_pkg::cfg_t     cfg;
  fpss_pkg::reg_idx_t reg_idx;
  logic               cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_period_us   <= fpss_pkg::BasePeriodReset;
      cfg.period_remainder <= fpss_pkg::PeriodRemReset;
      cfg.rate_hz          <= fpss_pkg::RateHzReset;
    end else if (cfg_write) begin
      // keep the low 20 bits; writes past the last register are dropped
      unique case (reg_idx)
        fpss_pkg::RegBasePeriod: cfg.base_period_us   <= pwdata[fpss_pkg::CfgW-1:0];
        fpss_pkg::RegPeriodRem:  cfg.period_remainder <= pwdata[fpss_pkg::CfgW-1:0];
        fpss_pkg::RegRateHz:     cfg.rate_hz          <= pwdata[fpss_pkg::CfgW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      fpss_pkg::RegBasePeriod: prdata = {12'd0, cfg.base_period_us};
      fpss_pkg::RegPeriodRem:  prdata = {12'd0, cfg.period_remainder};
      fpss_pkg::RegRateHz:     prdata = {12'd0, cfg.rate_hz};
      default:                 prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Pipeline control
  // --------------------------------------------------------------------------
  logic        in_valid;     // input register holds an item
  logic [31:0] in_now;
  logic        out_free;     // result register can load this cycle
  logic        advance;      // input item moves into the result register

  assign out_free  = !result_valid || !result_stall;
  assign advance   = in_valid && out_free;
  // Take a new item whenever the input register empties or is already empty.
  assign now_stall = in_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!now_stall) begin
      in_valid <= now_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (now_valid && !now_stall) begin
      in_now <= now_us;
    end
  end

  // --------------------------------------------------------------------------
  // Scheduler state and step logic
  // --------------------------------------------------------------------------
  fpss_pkg::sched_state_t state;
  fpss_pkg::sched_state_t state_next;
  fpss_pkg::result_t      step_result;
  fpss_pkg::result_t      result;

  fpss_step u_step (
    .now_us     (in_now),
    .cfg        (cfg),
    .state      (state),
    .state_next (state_next),
    .result     (step_result)
  );

  // Commit the state as the item leaves, so the next item sees it at once.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fpss_pkg::StateReset;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= step_result;
    end
  end

  assign fired            = result.fired;
  assign late_by_us       = result.late_by_us;
  assign fire_interval_us = result.fire_interval_us;
  assign reanchored       = result.reanchored;
  assign missed_total     = result.missed_total;

endmodule

@@ rtl/fpss_checker.sv @@
// ----------------------------------------------------------------------------
// fpss_port_checks
// Port-level checks on the sample scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`include "fractional_period_sample_scheduler_assert.svh"

module fpss_port_checks (
  input logic        clk,
  input logic        rst,
  input logic        result_valid,
  input logic        result_stall,
  input logic        fired,
  input logic [31:0] late_by_us,
  input logic [31:0] fire_interval_us,
  input logic        reanchored,
  input logic [31:0] missed_total
);

  // A held result keeps fired, late_by_us, fire_interval_us and missed_total.
  `FPSS_ASSERT_NEXT(a_result_hold, clk, rst, result_valid && result_stall, result_valid && $stable(fired) && $stable(late_by_us) && $stable(fire_interval_us) && $stable(missed_total))

  // Only a fire may report lateness, duration or a re-anchor.
  `FPSS_ASSERT_NOW(a_idle_fields_zero, clk, rst, result_valid && !fired, late_by_us == 32'd0 && fire_interval_us == 32'd0 && !reanchored)

  // A fire never shows a negative lateness.
  `FPSS_ASSERT_NOW(a_fire_not_early, clk, rst, result_valid && fired, !late_by_us[31])

  // A re-anchor counts a miss, so the total is never zero with it.
  `FPSS_ASSERT_NOW(a_reanchor_counted, clk, rst, result_valid && reanchored, fired && missed_total != 32'd0)

endmodule

bind fractional_period_sample_scheduler fpss_port_checks u_fpss_port_checks (.*);

@@ verif/fpss_checker.sv @@
// ----------------------------------------------------------------------------
// fpss_checker
// Watches the timestamp, result and register channels of the sample
// scheduler, predicts each result from its own copy of the schedule state
// and compares every field in order of arrival.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module fpss_checker (
  input  logic        clk,
  input  logic        rst,

  input  logic        now_valid,
  input  logic        now_stall,
  input  logic [31:0] now_us,

  input  logic        result_valid,
  input  logic        result_stall,
  input  logic        fired,
  input  logic [31:0] late_by_us,
  input  logic [31:0] fire_interval_us,
  input  logic        reanchored,
  input  logic [31:0] missed_total,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,

  output int unsigned fail_count,
  output int unsigned results_due,
  output int unsigned results_checked,
  output int unsigned fires_checked,
  output int unsigned reanchors_checked
);

  fpss_pkg::cfg_t         regs;
  fpss_pkg::sched_state_t sched;
  fpss_pkg::result_t      due_results[$];
  int unsigned            mismatches;
  int unsigned            checked;
  int unsigned            fires;
  int unsigned            reanchors;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("%0t: mismatch on %s at result %0d: got 0x%08h, want 0x%08h",
             $realtime, what, checked, got, want);
  endtask

  // One timestamp through the schedule; updates sched, returns the result.
  function automatic fpss_pkg::result_t schedule_step(
      input logic [fpss_pkg::TimeW-1:0] stamp);
    fpss_pkg::result_t          res;
    logic [fpss_pkg::TimeW-1:0] late;
    logic [fpss_pkg::TimeW-1:0] acc_sum;
    res = '0;
    if (!sched.deadline_loaded) begin
      sched.next_deadline   = stamp;
      sched.deadline_loaded = 1'b1;
    end
    late = stamp - sched.next_deadline;
    if (!late[fpss_pkg::TimeW-1]) begin
      res.fired      = 1'b1;
      res.late_by_us = late;
      // late >= base + 1 never overflows since base is only 20 bits
      if (late > 32'(regs.base_period_us)) begin
        sched.missed_count  = sched.missed_count + 1;
        sched.next_deadline = stamp;
        sched.remainder_acc = '0;
        res.reanchored      = 1'b1;
      end
      res.fire_interval_us     = sched.first_fire_pending ? '0
                                 : stamp - sched.previous_fire_time;
      sched.previous_fire_time = stamp;
      sched.first_fire_pending = 1'b0;
      sched.next_deadline      = sched.next_deadline + 32'(regs.base_period_us);
      acc_sum = 32'(sched.remainder_acc) + 32'(regs.period_remainder);
      if (acc_sum >= 32'(regs.rate_hz)) begin
        sched.next_deadline = sched.next_deadline + 1;
        acc_sum             = acc_sum - 32'(regs.rate_hz);
      end
      sched.remainder_acc = acc_sum[fpss_pkg::AccW-1:0];
    end
    res.missed_total = sched.missed_count;
    return res;
  endfunction

  always @(posedge clk) begin
    fpss_pkg::result_t  want;
    fpss_pkg::reg_idx_t idx;
    idx = paddr[3:2];
    if (rst) begin
      regs.base_period_us   = fpss_pkg::BasePeriodReset;
      regs.period_remainder = fpss_pkg::PeriodRemReset;
      regs.rate_hz          = fpss_pkg::RateHzReset;
      sched                 = fpss_pkg::StateReset;
      due_results.delete();
    end else begin
      // register port: writes update the mirror, reads compare against it
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (idx)
            fpss_pkg::RegBasePeriod: regs.base_period_us   = pwdata[fpss_pkg::CfgW-1:0];
            fpss_pkg::RegPeriodRem:  regs.period_remainder = pwdata[fpss_pkg::CfgW-1:0];
            fpss_pkg::RegRateHz:     regs.rate_hz          = pwdata[fpss_pkg::CfgW-1:0];
            default: ;
          endcase
        end else begin
          case (idx)
            fpss_pkg::RegBasePeriod: if (prdata !== 32'(regs.base_period_us))
                report_mismatch("base_period_us readback", prdata,
                                32'(regs.base_period_us));
            fpss_pkg::RegPeriodRem: if (prdata !== 32'(regs.period_remainder))
                report_mismatch("period_remainder readback", prdata,
                                32'(regs.period_remainder));
            fpss_pkg::RegRateHz: if (prdata !== 32'(regs.rate_hz))
                report_mismatch("rate_hz readback", prdata, 32'(regs.rate_hz));
            default: ;
          endcase
        end
      end

      if (now_valid && !now_stall)
        due_results.push_back(schedule_step(now_us));

      if (result_valid && !result_stall) begin
        if (due_results.size() == 0) begin
          report_mismatch("result with no item waiting", 32'(fired), 32'd0);
        end else begin
          want = due_results.pop_front();
          if (fired !== want.fired)
            report_mismatch("fired", 32'(fired), 32'(want.fired));
          if (late_by_us !== want.late_by_us)
            report_mismatch("late_by_us", late_by_us, want.late_by_us);
          if (fire_interval_us !== want.fire_interval_us)
            report_mismatch("fire_interval_us", fire_interval_us,
                            want.fire_interval_us);
          if (reanchored !== want.reanchored)
            report_mismatch("reanchored", 32'(reanchored), 32'(want.reanchored));
          if (missed_total !== want.missed_total)
            report_mismatch("missed_total", missed_total, want.missed_total);
          if (want.fired) fires++;
          if (want.reanchored) reanchors++;
        end
        checked++;
      end
    end
    fail_count        <= mismatches;
    results_due       <= due_results.size();
    results_checked   <= checked;
    fires_checked     <= fires;
    reanchors_checked <= reanchors;
  end

endmodule

@@ verif/tb_fractional_period_sample_scheduler.sv @@
// ----------------------------------------------------------------------------
// tb_fractional_period_sample_scheduler
// Drives timestamp items into the sample scheduler through a series of
// register settings, with random idle bursts on both channels, and leaves
// prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_fractional_period_sample_scheduler;

  // Index 3 decodes to no register; writes there must be dropped.
  localparam fpss_pkg::reg_idx_t RegUnmapped = 2'd3;
  // Cycles with no handshake on any channel before the run is declared hung.
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned TargetItems   = 950;
  localparam int unsigned CalmItems     = 100;

  logic        clk = 1'b0;
  logic        rst = 1'b1;

  logic        now_valid = 1'b0;
  logic        now_stall;
  logic [31:0] now_us = '0;

  logic        result_valid;
  logic        result_stall = 1'b0;
  logic        fired;
  logic [31:0] late_by_us;
  logic [31:0] fire_interval_us;
  logic        reanchored;
  logic [31:0] missed_total;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int unsigned fail_count;
  int unsigned results_due;
  int unsigned results_checked;
  int unsigned fires_checked;
  int unsigned reanchors_checked;

  // Stimulus bookkeeping
  logic [31:0]               stamp;      // running microsecond time fed to the block
  logic [fpss_pkg::CfgW-1:0] cur_base;   // last base period written, sizes the steps
  int unsigned     items_sent = 0;
  int unsigned     settings_used = 0;
  int unsigned     gap_pct = 0;     // chance of an idle burst before an item
  int unsigned     stall_pct = 0;   // chance per cycle of a result stall burst
  int unsigned     idle_cycles = 0;

  fractional_period_sample_scheduler u_dut (
    .clk              (clk),
    .rst              (rst),
    .now_valid        (now_valid),
    .now_stall        (now_stall),
    .now_us           (now_us),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .fired            (fired),
    .late_by_us       (late_by_us),
    .fire_interval_us (fire_interval_us),
    .reanchored       (reanchored),
    .missed_total     (missed_total),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  fpss_checker u_checker (
    .clk               (clk),
    .rst               (rst),
    .now_valid         (now_valid),
    .now_stall         (now_stall),
    .now_us            (now_us),
    .result_valid      (result_valid),
    .result_stall      (result_stall),
    .fired             (fired),
    .late_by_us        (late_by_us),
    .fire_interval_us  (fire_interval_us),
    .reanchored        (reanchored),
    .missed_total      (missed_total),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .fail_count        (fail_count),
    .results_due       (results_due),
    .results_checked   (results_checked),
    .fires_checked     (fires_checked),
    .reanchors_checked (reanchors_checked)
  );

  always begin
    #5;
    clk = 1'b1;
    #5;
    clk = 1'b0;
  end

  // Result side back-pressure: hold stall for a burst of random length, then
  // release it before the next burst so the checker sees the drain too.
  initial begin
    forever begin
      @(posedge clk);
      if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  // Hang detection: reset the count on any handshake, including register
  // accesses, and give up once it runs past the limit.
  always @(posedge clk) begin
    if (rst || (now_valid && !now_stall) || (result_valid && !result_stall) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("Timeout: no handshake for %0d cycles, %0d results still due",
               idle_cycles, results_due);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Setup cycle, then access cycle; the register takes the write at the
  // edge where penable and pready are both high. Lead with an idle cycle so
  // back-to-back accesses never drop and raise psel in the same step.
  task automatic reg_write(input fpss_pkg::reg_idx_t idx, input logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == fpss_pkg::RegBasePeriod) cur_base = data[fpss_pkg::CfgW-1:0];
  endtask

  // Readback is compared by the checker on the access edge.
  task automatic reg_read(input fpss_pkg::reg_idx_t idx);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Drop valid and hold the sender until every predicted result is back.
  // The checker's count is registered, so step once before testing it.
  task automatic drain_results();
    now_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Reprogram all three registers on an idle block. Junk in the upper
  // pwdata bits checks that only the low 20 bits are kept.
  task automatic apply_settings(input logic [fpss_pkg::CfgW-1:0] base,
                                input logic [fpss_pkg::CfgW-1:0] rem,
                                input logic [fpss_pkg::CfgW-1:0] rate,
                                input bit poke_unmapped);
    drain_results();
    reg_write(fpss_pkg::RegBasePeriod, {12'($urandom), base});
    reg_write(fpss_pkg::RegPeriodRem, {12'($urandom), rem});
    reg_write(fpss_pkg::RegRateHz, {12'($urandom), rate});
    if (poke_unmapped) reg_write(RegUnmapped, $urandom);
    reg_read(fpss_pkg::RegBasePeriod);
    reg_read(fpss_pkg::RegPeriodRem);
    reg_read(fpss_pkg::RegRateHz);
    settings_used++;
  endtask

  // Offer one timestamp item, optionally after an idle burst, and hold it
  // until the block takes it.
  task automatic send_stamp(input logic [31:0] t);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      now_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    now_valid <= 1'b1;
    now_us    <= t;
    @(posedge clk);
    while (now_stall) @(posedge clk);
    items_sent++;
  endtask

  // Mostly advance time in steps around the base period so deadlines are
  // hit, met exactly, or overrun. A few items jump far ahead to pull the
  // schedule out of a deadline stuck in the future, and a few land on a
  // random time to shake up the state.
  task automatic send_stamps(input int unsigned count);
    int unsigned pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 4)
        stamp = $urandom;
      else if (pick < 8)
        stamp = stamp + $urandom_range(32'h3000_0000, 32'h7000_0000);
      else if (pick < 18)
        stamp = stamp + $urandom_range(0, 1);
      else
        stamp = stamp + $urandom_range(0, 2 * 32'(cur_base) + 2);
      send_stamp(stamp);
    end
  endtask

  // Pick one of a few idle profiles, including none at all.
  task automatic pick_idle_profile();
    case ($urandom_range(0, 2))
      0: begin gap_pct = 0;  stall_pct = 0;  end
      1: begin gap_pct = 15; stall_pct = 10; end
      default: begin gap_pct = 40; stall_pct = 30; end
    endcase
  endtask

  // Random settings: mostly small periods with a proper remainder below the
  // rate, sometimes zero base, zero rate, or anything the registers hold.
  task automatic pick_settings();
    logic [fpss_pkg::CfgW-1:0] base;
    logic [fpss_pkg::CfgW-1:0] rem;
    logic [fpss_pkg::CfgW-1:0] rate;
    case ($urandom_range(0, 5))
      0: begin
        base = 20'($urandom);
        rem  = 20'($urandom);
        rate = 20'($urandom);
      end
      1: begin
        base = '0;
        rate = 20'($urandom_range(1, 20));
        rem  = 20'($urandom_range(0, 32'(rate) - 1));
      end
      default: begin
        base = 20'($urandom_range(1, 40));
        rate = 20'($urandom_range(1, 60));
        rem  = 20'($urandom_range(0, 32'(rate) - 1));
      end
    endcase
    if ($urandom_range(0, 15) == 0) rate = '0;
    apply_settings(base, rem, rate, $urandom_range(0, 3) == 0);
  endtask

  initial begin
    stamp    = 32'hFFFF_FC00;
    cur_base = fpss_pkg::BasePeriodReset;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset defaults, base 1250 and no remainder. Start just below the wrap
    // so the deadline crosses zero.
    send_stamp(stamp);                        // first item: anchor, fire, no duration
    send_stamp(stamp + 1);                    // early, no fire
    send_stamp(stamp + 1250);                 // exactly on time, across the wrap
    send_stamp(stamp + 2500 + 1250);          // late by exactly the base: no miss
    send_stamp(stamp + 5000 + 1251);          // late by twice the base plus one: re-anchor
    send_stamp(stamp + 7501 + 32'h8000_0000); // half the clock ahead reads as early
    send_stamp(stamp + 7501 + 32'h7FFF_FFFF); // largest lateness that still fires
    send_stamp(32'hFFFF_FFFF);                // all-ones time, late again
    send_stamp(32'h0000_0000);                // zero time, before the deadline

    // Zero base period: the deadline only moves through the accumulator and
    // any lateness at all re-anchors. Deadline sits at 0x4E1 from above.
    apply_settings('0, 20'd5, 20'd7, 1'b1);
    send_stamp(32'h0000_04E1);
    send_stamp(32'h0000_04E1);
    send_stamp(32'h0000_04E2);
    send_stamp(32'h0000_04E4);
    stamp = 32'h0000_04E4;
    gap_pct   = 20;
    stall_pct = 20;
    send_stamps(40);

    // Zero rate with the largest remainder: every fire adds the extra
    // microsecond and the accumulator wraps at 20 bits.
    apply_settings(20'd1, 20'hF_FFFF, '0, 1'b0);
    send_stamps(40);

    // Remainder far above the rate, with a one-second base period.
    apply_settings(20'd1_000_000, 20'd999_999, 20'd3, 1'b0);
    send_stamps(30);

    // Every register all ones, and a stray write to the unmapped index.
    apply_settings(20'hF_FFFF, 20'hF_FFFF, 20'hF_FFFF, 1'b1);
    stamp = 32'hFFFF_0000;
    send_stamps(30);

    // Random settings and idle profiles until the calm tail.
    while (items_sent < TargetItems - CalmItems) begin
      pick_settings();
      pick_idle_profile();
      if ($urandom_range(0, 5) == 0) stamp = 32'hFFFF_FFFF - $urandom_range(0, 200);
      send_stamps($urandom_range(30, 80));
    end

    // Tail with no idling on either side.
    gap_pct   = 0;
    stall_pct = 0;
    apply_settings(20'($urandom_range(1, 20)), 20'd3, 20'd7, 1'b0);
    send_stamps(CalmItems);

    drain_results();
    repeat (8) @(posedge clk);

    $display("Sent %0d timestamp items across %0d register settings after reset defaults.",
             items_sent, settings_used);
    $display("Checked %0d results: %0d fires, %0d re-anchored on a missed deadline.",
             results_checked, fires_checked, reanchors_checked);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ fractional_period_sample_scheduler.f @@
+incdir+rtl
rtl/fpss_pkg.sv
rtl/fpss_step.sv
rtl/fractional_period_sample_scheduler.sv
rtl/fpss_checker.sv
verif/fpss_checker.sv
verif/tb_fractional_period_sample_scheduler.sv
